// File: hw/rtl/lcw_pkg.sv
// Shared types, codes and constants for the load cell weigh and calibrate unit.
`timescale 1ns / 1ps
`default_nettype none
package lcw_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int FACTOR_W   = 41;
    localparam int CPG_W      = 42;
    localparam int GRAM_W     = 16;
    localparam int WEIGHT_W   = 24;
    localparam int PHASE_W    = 3;
    localparam int ELAPSED_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 41;

    // Shared divider operand widths
    localparam int DIV_N_W = 49;
    localparam int DIV_D_W = 42;

    // Average lengths
    localparam int DEF_TARE_SAMPLES = 16;
    localparam int DEF_CAL_SAMPLES  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CALW   = 3'd4;

    // Reset values of the configuration registers
    localparam logic signed [SAMPLE_W-1:0] RST_OFFSET = '0;
    localparam logic signed [CPG_W-1:0]    RST_FACTOR = 42'sd6553600;
    localparam logic [GRAM_W-1:0]          RST_MAXW   = 16'd5000;
    localparam logic [ELAPSED_W-1:0]       RST_STABLE = 16'd10000;
    localparam logic [GRAM_W-1:0]          RST_CALW   = 16'd200;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_TARE   = 2'd2,
        MODE_CAL    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TARE = 2'd1,
        KIND_CAL  = 2'd2
    } t_kind;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_EMPTY1 = 3'd1,
        PH_LOADED = 3'd2,
        PH_EMPTY2 = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WDIV,
        ST_COLLECT,
        ST_MDIV,
        ST_CFIN,
        ST_CDIFF,
        ST_CDIV
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/lcw_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none
interface lcw_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic signed [lcw_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, mode, sample, input ready);
    modport sink   (input valid, mode, sample, output ready);
endinterface

interface lcw_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 weight_valid;
    logic [lcw_pkg::WEIGHT_W-1:0]         weight_q8;
    logic [lcw_pkg::PHASE_W-1:0]          cal_phase;
    logic                                 averaging;
    logic signed [lcw_pkg::SAMPLE_W-1:0]  offset_now;
    logic signed [lcw_pkg::FACTOR_W-1:0]  factor_now;

    modport source (output valid, weight_valid, weight_q8, cal_phase, averaging,
                    offset_now, factor_now, input ready);
    modport sink   (input valid, weight_valid, weight_q8, cal_phase, averaging,
                    offset_now, factor_now, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/lcw_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lcw_div #(
    parameter int N_W = lcw_pkg::DIV_N_W,
    parameter int D_W = lcw_pkg::DIV_D_W
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [N_W-1:0]      o_quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_q;
    logic [D_W:0]     r_rem;
    logic [D_W-1:0]   r_div;

    logic [D_W:0] w_shift;
    logic         w_ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_shift = {r_rem[D_W-1:0], r_q[N_W-1]};
        w_ge    = (w_shift >= {1'b0, r_div});
    end

    // Control: iteration count and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(N_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_div}) : w_shift;
            r_q   <= {r_q[N_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

// File: hw/rtl/load_cell_weigh_and_calibrate_unit.sv
// Top level: load cell weighing with tare and three-phase two-point calibration.
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        mode[1:0], sample[23:0]
//  o_out    out  valid/ready        weight_valid, weight_q8, cal_phase, averaging,
//                                   offset_now, factor_now
//  i_cfg_*  in   write enable only  i_cfg_idx[2:0], i_cfg_data[40:0]
//
// A tick or a command passes through ST_EXEC back to ST_IDLE, a sample that needs
// no divide through ST_EXEC and ST_COLLECT, and one that does waits in ST_WDIV for
// the 49-step shared divider. A sample that closes an average adds a second 49-step
// divide, and the one that closes calibration a third.
// Reset is synchronous, clears control state and loads the configuration defaults.
// The input stays ready only in the idle state; a finished result waits in the output
// register while the next item is taken, and stalls the sequencer only if still unread.
`timescale 1ns / 1ps
`default_nettype none
module load_cell_weigh_and_calibrate_unit #(
    parameter int TARE_SAMPLES = lcw_pkg::DEF_TARE_SAMPLES,
    parameter int CAL_SAMPLES  = lcw_pkg::DEF_CAL_SAMPLES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    lcw_in_if.sink                                i_in,
    lcw_out_if.source                             o_out,
    input  wire logic                             i_cfg_we,
    input  wire logic [lcw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lcw_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int SW    = lcw_pkg::SAMPLE_W;
    localparam int MAXS  = (TARE_SAMPLES > CAL_SAMPLES) ? TARE_SAMPLES : CAL_SAMPLES;
    localparam int CNT_W = $clog2(MAXS + 1);
    localparam int SUM_W = SW + $clog2(MAXS) + 1;
    localparam int NW    = lcw_pkg::DIV_N_W;
    localparam int DW    = lcw_pkg::DIV_D_W;

    lcw_pkg::t_state r_state, n_state;
    lcw_pkg::t_mode  r_mode, n_mode;
    lcw_pkg::t_kind  r_kind, n_kind;
    lcw_pkg::t_phase r_phase, n_phase;

    logic signed [SW-1:0]              r_sample, n_sample;
    logic signed [SW-1:0]              r_offset, n_offset;
    logic signed [lcw_pkg::CPG_W-1:0]  r_cpg, n_cpg;
    logic [lcw_pkg::ELAPSED_W-1:0]     r_elapsed, n_elapsed;
    logic signed [SUM_W-1:0]           r_sum, n_sum;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic signed [SW-1:0]              r_e1, n_e1;
    logic signed [SW-1:0]              r_loaded, n_loaded;
    logic [lcw_pkg::WEIGHT_W-1:0]      r_weight, n_weight;
    logic                              r_neg, n_neg;
    logic [lcw_pkg::GRAM_W-1:0]        r_maxw, n_maxw;
    logic [lcw_pkg::ELAPSED_W-1:0]     r_stable, n_stable;
    logic [lcw_pkg::GRAM_W-1:0]        r_calw, n_calw;

    logic                              r_ovalid;
    logic                              r_o_wvalid;
    logic [lcw_pkg::WEIGHT_W-1:0]      r_o_weight;
    logic [lcw_pkg::PHASE_W-1:0]       r_o_phase;
    logic                              r_o_avg;
    logic signed [SW-1:0]              r_o_offset;
    logic signed [lcw_pkg::FACTOR_W-1:0] r_o_factor;

    logic          w_out_free;
    logic          w_load_out;
    logic          w_div_start;
    logic [NW-1:0] w_div_n;
    logic [DW-1:0] w_div_d;
    logic          w_div_busy;
    logic          w_div_done;
    logic [NW-1:0] w_div_q;

    logic signed [SW:0]    w_diff;
    logic [SW:0]           w_dmag;
    logic [DW-1:0]         w_cmag;
    logic [CNT_W-1:0]      w_target;
    logic [SUM_W-1:0]      w_smag;
    logic signed [SW-1:0]  w_mean;
    logic signed [SW:0]    w_esum;
    logic [lcw_pkg::WEIGHT_W-1:0] w_lim;
    logic [lcw_pkg::ELAPSED_W-1:0] w_el_inc;

    lcw_div #(.N_W(NW), .D_W(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == lcw_pkg::ST_IDLE);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcw_pkg::ST_IDLE: begin
                if (i_in.valid) n_state = lcw_pkg::ST_EXEC;
            end
            lcw_pkg::ST_EXEC: begin
                if (r_mode != lcw_pkg::MODE_SAMPLE) n_state = lcw_pkg::ST_IDLE;
                else if (w_div_start) n_state = lcw_pkg::ST_WDIV;
                else n_state = lcw_pkg::ST_COLLECT;
                if (r_mode != lcw_pkg::MODE_SAMPLE && !w_out_free) n_state = lcw_pkg::ST_EXEC;
            end
            lcw_pkg::ST_WDIV: begin
                if (w_div_done) n_state = lcw_pkg::ST_COLLECT;
            end
            lcw_pkg::ST_COLLECT: begin
                if (w_div_start) n_state = lcw_pkg::ST_MDIV;
                else if (w_out_free) n_state = lcw_pkg::ST_IDLE;
            end
            lcw_pkg::ST_MDIV: begin
                if (w_div_done) begin
                    if (r_kind == lcw_pkg::KIND_CAL && r_phase == lcw_pkg::PH_EMPTY2)
                        n_state = lcw_pkg::ST_CFIN;
                    else
                        n_state = lcw_pkg::ST_COLLECT;
                end
            end
            lcw_pkg::ST_CFIN:  n_state = lcw_pkg::ST_CDIFF;
            lcw_pkg::ST_CDIFF: begin
                if (w_div_start) n_state = lcw_pkg::ST_CDIV;
                else n_state = lcw_pkg::ST_COLLECT;
            end
            lcw_pkg::ST_CDIV: begin
                if (w_div_done) n_state = lcw_pkg::ST_COLLECT;
            end
            default: n_state = lcw_pkg::ST_IDLE;
        endcase
    end

    // Shared operand shaping
    always_comb begin
        w_diff   = (SW+1)'(r_sample) - (SW+1)'(r_offset);
        w_dmag   = w_diff[SW] ? (SW+1)'(-w_diff) : (SW+1)'(w_diff);
        w_cmag   = r_cpg[DW-1] ? DW'(-r_cpg) : DW'(r_cpg);
        w_target = (r_kind == lcw_pkg::KIND_TARE) ? CNT_W'(TARE_SAMPLES) : CNT_W'(CAL_SAMPLES);
        w_smag   = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        w_mean   = r_neg ? SW'(-w_div_q) : SW'(w_div_q);
        w_esum   = (SW+1)'(r_e1) + (SW+1)'(r_sample);
        w_lim    = {r_maxw, 8'd0};
        w_el_inc = (r_elapsed == '1) ? r_elapsed : (r_elapsed + 1'b1);
    end

    // Datapath and divider requests
    always_comb begin
        n_mode    = r_mode;
        n_kind    = r_kind;
        n_phase   = r_phase;
        n_sample  = r_sample;
        n_offset  = r_offset;
        n_cpg     = r_cpg;
        n_elapsed = r_elapsed;
        n_sum     = r_sum;
        n_count   = r_count;
        n_e1      = r_e1;
        n_loaded  = r_loaded;
        n_weight  = r_weight;
        n_neg     = r_neg;
        n_maxw    = r_maxw;
        n_stable  = r_stable;
        n_calw    = r_calw;
        w_div_start = 1'b0;
        w_div_n     = '0;
        w_div_d     = '0;
        w_load_out  = 1'b0;

        case (r_state)
            lcw_pkg::ST_IDLE: begin
                // Take the item
                if (i_in.valid) begin
                    n_mode   = lcw_pkg::t_mode'(i_in.mode);
                    n_sample = i_in.sample;
                    n_weight = '0;
                end
            end
            lcw_pkg::ST_EXEC: begin
                case (r_mode)
                    lcw_pkg::MODE_SAMPLE: begin
                        // Only a positive quotient can give a weight
                        if (r_cpg != '0 && w_diff != '0 && (w_diff[SW] == r_cpg[DW-1])) begin
                            w_div_start = 1'b1;
                            w_div_n     = NW'({w_dmag, 24'd0});
                            w_div_d     = w_cmag;
                        end
                    end
                    lcw_pkg::MODE_TICK: begin
                        if (w_out_free && r_kind == lcw_pkg::KIND_NONE &&
                            (r_phase == lcw_pkg::PH_EMPTY1 || r_phase == lcw_pkg::PH_LOADED ||
                             r_phase == lcw_pkg::PH_EMPTY2)) begin
                            n_elapsed = w_el_inc;
                            if (w_el_inc >= r_stable) begin
                                n_kind  = lcw_pkg::KIND_CAL;
                                n_sum   = '0;
                                n_count = '0;
                            end
                        end
                    end
                    lcw_pkg::MODE_TARE: begin
                        if (w_out_free && r_kind == lcw_pkg::KIND_NONE) begin
                            n_kind  = lcw_pkg::KIND_TARE;
                            n_sum   = '0;
                            n_count = '0;
                        end
                    end
                    lcw_pkg::MODE_CAL: begin
                        if (w_out_free && r_kind == lcw_pkg::KIND_NONE) begin
                            n_phase   = lcw_pkg::PH_EMPTY1;
                            n_elapsed = '0;
                        end
                    end
                    default: ;
                endcase
                if (r_mode != lcw_pkg::MODE_SAMPLE && w_out_free) w_load_out = 1'b1;
            end
            lcw_pkg::ST_WDIV: begin
                // Clamp the quotient
                if (w_div_done) begin
                    if (w_div_q < NW'(256))         n_weight = '0;
                    else if (w_div_q > NW'(w_lim))  n_weight = w_lim;
                    else                            n_weight = w_div_q[lcw_pkg::WEIGHT_W-1:0];
                end
            end
            lcw_pkg::ST_COLLECT: begin
                // Accumulate into a running average once the result slot is free, then finish
                if (r_kind != lcw_pkg::KIND_NONE && r_count != w_target) begin
                    if (w_out_free) begin
                        n_sum   = r_sum + SUM_W'(r_sample);
                        n_count = r_count + 1'b1;
                        if (n_count == w_target) begin
                            w_div_start = 1'b1;
                            w_div_n     = NW'(w_smag);
                            w_div_d     = DW'(n_count);
                            n_neg       = n_sum[SUM_W-1];
                        end else begin
                            w_load_out = 1'b1;
                        end
                    end
                end else if (w_out_free) begin
                    w_load_out = 1'b1;
                end
            end
            lcw_pkg::ST_MDIV: begin
                if (w_div_done) begin
                    if (r_kind == lcw_pkg::KIND_TARE) begin
                        n_offset = w_mean;
                    end else begin
                        case (r_phase)
                            lcw_pkg::PH_EMPTY1: begin
                                n_e1    = w_mean;
                                n_phase = lcw_pkg::PH_LOADED;
                            end
                            lcw_pkg::PH_LOADED: begin
                                n_loaded = w_mean;
                                n_phase  = lcw_pkg::PH_EMPTY2;
                            end
                            lcw_pkg::PH_EMPTY2: begin
                                // Park the second empty reading in the sample slot
                                n_sample = w_mean;
                            end
                            default: ;
                        endcase
                        n_elapsed = '0;
                    end
                    n_kind  = lcw_pkg::KIND_NONE;
                    n_sum   = '0;
                    n_count = '0;
                end
            end
            lcw_pkg::ST_CFIN: begin
                // Mean of the two empty readings, rounded toward zero
                n_offset = SW'((w_esum + (SW+1)'(w_esum[SW])) >>> 1);
            end
            lcw_pkg::ST_CDIFF: begin
                n_phase = lcw_pkg::PH_DONE;
                if (w_diff != '0 && r_calw != '0) begin
                    w_div_start = 1'b1;
                    w_div_n     = NW'({w_dmag, 16'd0});
                    w_div_d     = DW'(r_calw);
                    n_neg       = w_diff[SW];
                end
            end
            lcw_pkg::ST_CDIV: begin
                if (w_div_done)
                    n_cpg = r_neg ? lcw_pkg::CPG_W'(-w_div_q) : lcw_pkg::CPG_W'(w_div_q);
            end
            default: ;
        endcase

        // The calibration difference reuses the sample slot as loaded reading
        if (r_state == lcw_pkg::ST_CFIN) n_sample = r_loaded;

        // Configuration writes
        if (i_cfg_we) begin
            case (i_cfg_idx)
                lcw_pkg::CFG_OFFSET: n_offset = i_cfg_data[SW-1:0];
                lcw_pkg::CFG_FACTOR: n_cpg    = lcw_pkg::CPG_W'($signed(i_cfg_data));
                lcw_pkg::CFG_MAXW:   n_maxw   = i_cfg_data[lcw_pkg::GRAM_W-1:0];
                lcw_pkg::CFG_STABLE: n_stable = i_cfg_data[lcw_pkg::ELAPSED_W-1:0];
                lcw_pkg::CFG_CALW:   n_calw   = i_cfg_data[lcw_pkg::GRAM_W-1:0];
                default: ;
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lcw_pkg::ST_IDLE;
            r_kind    <= lcw_pkg::KIND_NONE;
            r_phase   <= lcw_pkg::PH_IDLE;
            r_offset  <= lcw_pkg::RST_OFFSET;
            r_cpg     <= lcw_pkg::RST_FACTOR;
            r_elapsed <= '0;
            r_sum     <= '0;
            r_count   <= '0;
            r_e1      <= '0;
            r_loaded  <= '0;
            r_maxw    <= lcw_pkg::RST_MAXW;
            r_stable  <= lcw_pkg::RST_STABLE;
            r_calw    <= lcw_pkg::RST_CALW;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_kind    <= n_kind;
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_cpg     <= n_cpg;
            r_elapsed <= n_elapsed;
            r_sum     <= n_sum;
            r_count   <= n_count;
            r_e1      <= n_e1;
            r_loaded  <= n_loaded;
            r_maxw    <= n_maxw;
            r_stable  <= n_stable;
            r_calw    <= n_calw;
            if (w_load_out)       r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    // Item payload and result register
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_sample <= n_sample;
        r_weight <= n_weight;
        r_neg    <= n_neg;
        if (w_load_out) begin
            r_o_wvalid <= (r_mode == lcw_pkg::MODE_SAMPLE);
            r_o_weight <= n_weight;
            r_o_phase  <= n_phase;
            r_o_avg    <= (n_kind != lcw_pkg::KIND_NONE);
            r_o_offset <= n_offset;
            r_o_factor <= n_cpg[lcw_pkg::FACTOR_W-1:0];
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.weight_valid = r_o_wvalid;
    assign o_out.weight_q8    = r_o_weight;
    assign o_out.cal_phase    = r_o_phase;
    assign o_out.averaging    = r_o_avg;
    assign o_out.offset_now   = r_o_offset;
    assign o_out.factor_now   = r_o_factor;

    // Divider results arrive only while a divide state waits for them
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == lcw_pkg::ST_WDIV || r_state == lcw_pkg::ST_MDIV ||
                        r_state == lcw_pkg::ST_CDIV))
        else $error("divider finished outside a divide state");

    // The divider is never restarted while busy
    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    // A running average never holds its full count between items
    a_avg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcw_pkg::ST_IDLE && r_kind != lcw_pkg::KIND_NONE) |-> (r_count < w_target))
        else $error("average count reached target while idle");

    // A nonzero weight belongs only to a sample result
    a_weight_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_weight != '0) |-> r_o_wvalid)
        else $error("weight reported for a non-sample item");

endmodule
`default_nettype wire
